FILE: src/pcmpp_pkg.sv
// Shared types, constants and helpers for the PCM FIFO PWM player.
package pcmpp_pkg;

  // Ring FIFO depth; holds FIFO_DEPTH-1 samples (one slot kept free).
  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Interpolation: two SAMPLE_W x TICK_W products summed, then shifted.
  localparam int unsigned INTERP_SHIFT = 2;
  localparam int unsigned ACC_W        = SAMPLE_W + TICK_W + 1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [TICK_W-1:0]   tick_t;
  typedef logic [PTR_W-1:0]    ptr_t;

  localparam sample_t SILENCE_LEVEL  = sample_t'(128);
  localparam sample_t DUTY_RESET     = sample_t'(8'hFF);
  localparam tick_t   TPS_RESET      = tick_t'(4);

  typedef enum logic [1:0] {
    OpPush  = 2'd0,
    OpTick  = 2'd1,
    OpStart = 2'd2,
    OpStop  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgTicksPerSample = 1'b0,
    CfgHighResolution = 1'b1
  } cfg_idx_e;

  // Player -> FIFO control.
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    clear;
    sample_t wdata;
  } fifo_ctrl_t;

  // FIFO -> player status.
  typedef struct packed {
    logic    empty;
    logic    full;
    sample_t rdata;
  } fifo_sts_t;

  // One result beat.
  typedef struct packed {
    sample_t duty;
    logic    duty_updated;
    logic    push_rejected;
    logic    underrun;
  } result_t;

  function automatic ptr_t ptr_next(ptr_t p);
    ptr_t n;
    n = (p == ptr_t'(FIFO_DEPTH - 1)) ? '0 : p + ptr_t'(1);
    return n;
  endfunction

endpackage

FILE: src/pcmpp_if.sv
// Valid/ready channel interfaces for command beats and result beats.
interface pcmpp_in_if import pcmpp_pkg::*; ();
  logic    valid;
  logic    ready;
  op_e     operation;
  sample_t sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface pcmpp_out_if import pcmpp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t duty;
  logic    duty_updated;
  logic    push_rejected;
  logic    underrun;

  modport source (output valid, output duty, output duty_updated, output push_rejected,
                  output underrun, input ready);
  modport sink   (input valid, input duty, input duty_updated, input push_rejected,
                  input underrun, output ready);
endinterface

FILE: src/pcmpp_fifo.sv
// Sample ring FIFO: flop storage, write/read pointers, full/empty status.
module pcmpp_fifo import pcmpp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fifo_ctrl_t ctrl_i,
  output fifo_sts_t  sts_o
);

  sample_t store_q [FIFO_DEPTH];
  ptr_t    wr_ptr_q, wr_ptr_d;
  ptr_t    rd_ptr_q, rd_ptr_d;
  logic    full, empty, do_push;

  assign empty   = (wr_ptr_q == rd_ptr_q);
  assign full    = (ptr_next(wr_ptr_q) == rd_ptr_q);
  assign do_push = ctrl_i.push && !full;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (ctrl_i.clear) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
    end else begin
      if (do_push) wr_ptr_d = ptr_next(wr_ptr_q);
      if (ctrl_i.pop && !empty) rd_ptr_d = ptr_next(rd_ptr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // no reset on storage: only written slots are ever read
  always_ff @(posedge clk_i) begin
    if (do_push && !ctrl_i.clear) store_q[wr_ptr_q] <= ctrl_i.wdata;
  end

  assign sts_o.empty = empty;
  assign sts_o.full  = full;
  assign sts_o.rdata = store_q[rd_ptr_q];

endmodule

FILE: src/pcmpp_duty.sv
// Player state: divider, current sample, duty register, interpolation.
module pcmpp_duty import pcmpp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       exec_i,
  input  op_e        op_i,
  input  sample_t    sample_i,
  input  tick_t      tps_i,
  input  logic       hires_i,
  input  fifo_sts_t  fifo_sts_i,
  output fifo_ctrl_t fifo_ctrl_o,
  output result_t    result_o
);

  tick_t   tick_q, tick_d;
  sample_t cur_q, cur_d;
  sample_t duty_q, duty_d;
  logic    running_q, running_d;

  tick_t                        tick_inc, tick_rem;
  logic                         due;
  logic [SAMPLE_W+TICK_W-1:0]   prod_next, prod_cur;
  logic [ACC_W-1:0]             acc;
  logic [ACC_W-INTERP_SHIFT-1:0] acc_sh;
  sample_t                      interp;

  assign tick_inc = tick_q + tick_t'(1);
  assign due      = (tick_inc >= tps_i);
  // only used when !due, so tick_inc < tps and the difference is positive
  assign tick_rem = tps_i - tick_inc;

  assign prod_next = tick_inc * fifo_sts_i.rdata;
  assign prod_cur  = tick_rem * cur_q;
  assign acc       = ACC_W'(prod_next) + ACC_W'(prod_cur);
  assign acc_sh    = acc[ACC_W-1:INTERP_SHIFT];
  assign interp    = (|acc_sh[ACC_W-INTERP_SHIFT-1:SAMPLE_W]) ? DUTY_RESET
                                                              : acc_sh[SAMPLE_W-1:0];

  always_comb begin
    tick_d      = tick_q;
    cur_d       = cur_q;
    duty_d      = duty_q;
    running_d   = running_q;
    fifo_ctrl_o = '{push: 1'b0, pop: 1'b0, clear: 1'b0, wdata: sample_i};
    result_o    = '0;
    if (exec_i) begin
      unique case (op_i)
        OpPush: begin
          fifo_ctrl_o.push       = 1'b1;
          result_o.push_rejected = fifo_sts_i.full;
        end
        OpTick: begin
          if (running_q) begin
            if (due) begin
              tick_d = '0;
              if (!fifo_sts_i.empty) begin
                cur_d                 = fifo_sts_i.rdata;
                duty_d                = fifo_sts_i.rdata;
                fifo_ctrl_o.pop       = 1'b1;
                result_o.duty_updated = 1'b1;
              end else begin
                result_o.underrun = 1'b1;
              end
            end else begin
              tick_d = tick_inc;
              if (hires_i && !fifo_sts_i.empty) begin
                duty_d                = interp;
                result_o.duty_updated = 1'b1;
              end
            end
          end
        end
        OpStart: begin
          fifo_ctrl_o.clear = 1'b1;
          tick_d            = '0;
          cur_d             = SILENCE_LEVEL;
          running_d         = 1'b1;
        end
        OpStop: running_d = 1'b0;
      endcase
    end
    result_o.duty = duty_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      cur_q     <= SILENCE_LEVEL;
      duty_q    <= DUTY_RESET;
      running_q <= 1'b0;
    end else begin
      tick_q    <= tick_d;
      cur_q     <= cur_d;
      duty_q    <= duty_d;
      running_q <= running_d;
    end
  end

endmodule

FILE: src/pcm_fifo_pwm_player.sv
// Top level of the PCM FIFO PWM player: command register, player, result register.
//
//  channel   dir  handshake      payload
//  -------   ---  ---------      -------
//  cmd_in    in   valid/ready    operation[1:0], sample[7:0]
//  res_out   out  valid/ready    duty[7:0], duty_updated, push_rejected, underrun
//  cfg       in   cfg_we_i       cfg_idx_i (0 ticks_per_sample, 1 high_resolution),
//                                cfg_wdata_i[7:0]
//
// Every command beat yields exactly one result beat, registered first in the command
// register and then in the result register.
// Throughput is one beat per cycle while the result side is not stalled.
// Reset (rst_ni low, async) empties the FIFO, stops playback, duty 255, current 128,
// ticks_per_sample 4, high_resolution 0. A stalled result holds both registers; the
// command register still takes a beat while it is empty.
module pcm_fifo_pwm_player import pcmpp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pcmpp_in_if.sink             cmd_in,
  pcmpp_out_if.source          res_out,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // configuration registers
  tick_t tps_q;
  logic  hires_q;

  // command register
  logic    cmd_valid_q;
  op_e     cmd_op_q;
  sample_t cmd_sample_q;

  // result register
  logic    res_valid_q;
  result_t res_q;

  logic       advance, cmd_accept;
  fifo_ctrl_t fifo_ctrl;
  fifo_sts_t  fifo_sts;
  result_t    result;

  // command moves into the player when the result slot is free or being drained
  assign advance    = cmd_valid_q && (!res_valid_q || res_out.ready);
  assign cmd_in.ready = !cmd_valid_q || advance;
  assign cmd_accept = cmd_in.valid && cmd_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q   <= TPS_RESET;
      hires_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTicksPerSample: tps_q   <= cfg_wdata_i[TICK_W-1:0];
        CfgHighResolution: hires_q <= cfg_wdata_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_accept) cmd_valid_q <= 1'b1;
      else if (advance) cmd_valid_q <= 1'b0;
      if (advance) res_valid_q <= 1'b1;
      else if (res_out.ready) res_valid_q <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_accept) begin
      cmd_op_q     <= cmd_in.operation;
      cmd_sample_q <= cmd_in.sample;
    end
    if (advance) res_q <= result;
  end

  pcmpp_duty u_duty (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .exec_i      (advance),
    .op_i        (cmd_op_q),
    .sample_i    (cmd_sample_q),
    .tps_i       (tps_q),
    .hires_i     (hires_q),
    .fifo_sts_i  (fifo_sts),
    .fifo_ctrl_o (fifo_ctrl),
    .result_o    (result)
  );

  pcmpp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fifo_ctrl),
    .sts_o  (fifo_sts)
  );

  assign res_out.valid         = res_valid_q;
  assign res_out.duty          = res_q.duty;
  assign res_out.duty_updated  = res_q.duty_updated;
  assign res_out.push_rejected = res_q.push_rejected;
  assign res_out.underrun      = res_q.underrun;

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $countones({res_q.duty_updated, res_q.push_rejected, res_q.underrun}) <= 1)
    else $error("more than one result flag set");

  a_start_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_op_q == OpStart) |=> fifo_sts.empty)
    else $error("FIFO not empty after start");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_op_q == OpPush && !fifo_sts.full) |=> !fifo_sts.empty)
    else $error("accepted push left FIFO empty");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("executed command produced no result beat");
`endif

endmodule
